// ===== design/lskt_pkg.sv =====
// Shared types, codes and field widths for the linear search key table.
// No dependencies; every other file but lskt_ram imports this package.
`default_nettype none

package lskt_pkg;

    // Default table capacity
    localparam int LSKT_CAPACITY = 256;

    // Field widths of one request and one result
    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 8;
    localparam int CNT_OUT_W = 9;

    // Packed stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = OP_W + KEY_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + POS_W + CNT_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    // One finished result, as handed from the sequencer to the output stage
    typedef struct packed {
        logic [CNT_OUT_W-1:0] entry_count;
        logic [POS_W-1:0]     position;
        logic [STATUS_W-1:0]  status;
    } lskt_result_t;

endpackage

`default_nettype wire

// ===== design/lskt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the key store; no package dependencies.
`default_nettype none

module lskt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/lskt_seq.sv =====
// Sequencer of the key table: entry count, scan index and one shared key compare.
// Depends on lskt_pkg; drives the ports of one lskt_ram instance.
`default_nettype none

module lskt_seq
    import lskt_pkg::*;
#(
    parameter int CAPACITY = LSKT_CAPACITY,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Request handed over at a transfer on the input channel
    input  wire logic             start,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [KEY_W-1:0] key,
    // Finished result
    output logic                  done,
    output lskt_result_t          result,
    output logic                  busy,
    // Key store port
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [KEY_W-1:0]      ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  wire logic [KEY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    logic [CNT_W-1:0]  cnt_last;
    logic [CNT_W-1:0]  cnt_inc;
    logic              is_full;
    logic              key_hit;

    assign cnt_last = count_reg - CNT_W'(1);
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign key_hit  = (ram_rdata == key_reg);
    assign busy     = (state_reg != S_IDLE);

    // Next-state logic: one stored entry is compared per cycle while scanning
    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        op_next            = op_reg;
        key_next           = key_reg;
        pend_idx_next      = pend_idx_reg;
        done               = 1'b0;
        result.status      = STAT_NOT_FOUND;
        result.position    = '0;
        result.entry_count = CNT_OUT_W'(count_reg);
        ram_we             = 1'b0;
        ram_waddr          = count_reg[IDX_W-1:0];
        ram_wdata          = key;
        ram_raddr          = pend_idx_reg - IDX_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next  = op;
                    key_next = key;
                    unique case (op)
                        OP_INSERT: begin
                            done = 1'b1;
                            if (is_full) begin
                                result.status = STAT_FULL;
                            end else begin
                                ram_we             = 1'b1;
                                count_next         = cnt_inc;
                                result.status      = STAT_OK;
                                result.position    = POS_W'(count_reg[IDX_W-1:0]);
                                result.entry_count = CNT_OUT_W'(cnt_inc);
                            end
                        end
                        OP_REMOVE, OP_SEARCH: begin
                            if (count_reg == '0) begin
                                done = 1'b1;
                            end else begin
                                ram_raddr     = cnt_last[IDX_W-1:0];
                                pend_idx_next = cnt_last[IDX_W-1:0];
                                state_next    = S_SCAN;
                            end
                        end
                        default: begin
                            // Unused code: answered as not found, nothing changes.
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read data belongs to the entry at pend_idx_reg.
                if (key_hit) begin
                    if (op_reg == OP_REMOVE) begin
                        ram_raddr  = cnt_last[IDX_W-1:0];
                        state_next = S_MOVE;
                    end else begin
                        done            = 1'b1;
                        result.status   = STAT_OK;
                        result.position = POS_W'(pend_idx_reg);
                        state_next      = S_IDLE;
                    end
                end else if (pend_idx_reg == '0) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    pend_idx_next = pend_idx_reg - IDX_W'(1);
                end
            end
            S_MOVE: begin
                // The last entry fills the slot of the removed key.
                ram_we             = 1'b1;
                ram_waddr          = pend_idx_reg;
                ram_wdata          = ram_rdata;
                count_next         = cnt_last;
                done               = 1'b1;
                result.status      = STAT_OK;
                result.position    = POS_W'(pend_idx_reg);
                result.entry_count = CNT_OUT_W'(cnt_last);
                state_next         = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Request payload and scan index
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
    end

endmodule

`default_nettype wire

// ===== design/linear_search_key_table.sv =====
// Top level of the linear search key table: stream ports, result register, assertions.
// Depends on lskt_pkg, lskt_seq and lskt_ram.
//
//  Channel  Direction  Payload (low bit up)                            Transfer
//  s_       in         tdata: operation[1:0], key[33:2], zero pad      tvalid & tready
//  m_       out        tdata: status[1:0], position[9:2],              tvalid & tready
//                      entry_count[18:10], zero pad
//
// Insert and unused codes, and remove or search on an empty table, finish in the
// cycle of the input transfer. Otherwise remove and search compare entries newest
// first, one per cycle through the registered read port of the key store; remove
// then adds a move state that copies the last entry into the freed slot.
// Synchronous reset empties the table at once; the key store needs no clearing.
// s_tready is high only while the sequencer is idle and the result register is
// free or being emptied in that cycle.
`default_nettype none

module linear_search_key_table
    import lskt_pkg::*;
#(
    parameter int CAPACITY = LSKT_CAPACITY
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Request stream: operation, key
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream: status, position, entry_count
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                   start;
    logic [OP_W-1:0]        in_op;
    logic signed [KEY_W-1:0] in_key;
    logic                   done;
    lskt_result_t           result;
    logic                   busy;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [KEY_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [KEY_W-1:0]       ram_rdata;

    logic                   m_tvalid_reg, m_tvalid_next;
    lskt_result_t           m_res_reg;

    // Input unpacking and handshake
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_key   = s_tdata[OP_W +: KEY_W];
    assign s_tready = !busy && (!m_tvalid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    lskt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .op        (in_op),
        .key       (in_key),
        .done      (done),
        .result    (result),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lskt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload, loaded when the sequencer finishes an item
    always_ff @(posedge aclk) begin
        if (done) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, m_res_reg};

    // A result never overwrites one that has not been transferred yet.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (!m_tvalid_reg || m_tready))
        else $error("result finished while previous result still pending");

    // No request is taken while a scan or move is in progress.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input ready while sequencer busy");

    // A busy sequencer started from a transfer.
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(busy) |-> $past(start)))
        else $error("sequencer left idle without an input transfer");

    // Refused or missed operations report position zero.
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && (result.status == STAT_FULL || result.status == STAT_NOT_FOUND))
        |-> (result.position == '0))
        else $error("nonzero position on a refused or missed operation");

endmodule

`default_nettype wire

// ===== sim/lskt_checker.sv =====
// Result checker for the linear search key table: it watches the request and result
// channels, predicts every result from its own copy of the table and compares them.
// Depends on lskt_pkg for field widths, operation codes and status codes.

module lskt_result_checker
    import lskt_pkg::*;
#(
    parameter int CAPACITY = LSKT_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation, key
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // status, position, entry_count
    output int                     fail_count,
    output int                     results_pending
);

    // Shadow copy of the table: stored keys and how many are valid.
    logic [KEY_W-1:0] stored_keys [CAPACITY];
    int               live_count;

    // Results predicted for accepted requests, oldest first.
    lskt_result_t     pending_results [$];

    // Finds the highest index holding the key, scanning from the newest entry down.
    function automatic bit find_newest(input logic [KEY_W-1:0] key, output int slot);
        slot = 0;
        for (int i = live_count - 1; i >= 0; i--) begin
            if (stored_keys[i] == key) begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic lskt_result_t update_table(input logic [OP_W-1:0]  op,
                                                  input logic [KEY_W-1:0] key);
        lskt_result_t res;
        int           slot;
        res.status   = STAT_NOT_FOUND;
        res.position = '0;
        case (op)
            OP_INSERT: begin
                if (live_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    stored_keys[live_count] = key;
                    res.position = POS_W'(live_count);
                    live_count++;
                    res.status = STAT_OK;
                end
            end
            OP_REMOVE: begin
                // The last entry moves into the freed slot.
                if (find_newest(key, slot)) begin
                    stored_keys[slot] = stored_keys[live_count - 1];
                    live_count--;
                    res.position = POS_W'(slot);
                    res.status   = STAT_OK;
                end
            end
            OP_SEARCH: begin
                if (find_newest(key, slot)) begin
                    res.position = POS_W'(slot);
                    res.status   = STAT_OK;
                end
            end
            default: begin
                // The unused code leaves the table alone and reports not found.
            end
        endcase
        res.entry_count = CNT_OUT_W'(live_count);
        return res;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [CNT_OUT_W-1:0] want,
                                          input logic [CNT_OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Results are checked before the same edge's request is predicted, since a
    // result can never belong to a request accepted at that very edge.
    always @(posedge aclk) begin : watch_channels
        lskt_result_t got;
        lskt_result_t want;
        if (!aresetn) begin
            live_count = 0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = lskt_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", CNT_OUT_W'(want.status), CNT_OUT_W'(got.status));
                    compare_field("position", CNT_OUT_W'(want.position),
                                  CNT_OUT_W'(got.position));
                    compare_field("entry_count", want.entry_count, got.entry_count);
                end
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(update_table(s_tdata[OP_W-1:0],
                                                       s_tdata[OP_W +: KEY_W]));
            end
        end
        results_pending = pending_results.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the linear search key table: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on lskt_pkg, the block
// and lskt_result_checker, which does all prediction and comparison.

module tb;
    import lskt_pkg::*;

    localparam int              CAPACITY        = LSKT_CAPACITY;
    localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
    localparam int              TOTAL_REQUESTS  = 450;
    localparam int              CALM_TAIL       = 60;
    localparam int              HOLD_OFF_AT     = 120;
    localparam int              HOLD_OFF_CYCLES = 400;
    // Longest correct quiet spell is the hold-off plus a full scan; allow several times that.
    localparam int              WATCHDOG_LIMIT  = 3000;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // operation[1:0], key[33:2], zero pad
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // status[1:0], position[9:2], entry_count[18:10]

    int                     mismatch_count;
    int                     results_pending;
    int                     requests_accepted = 0;

    // Keys believed to be in the table, used to steer keys toward hits and to track when it is full.
    logic [KEY_W-1:0]       known_keys [$];
    int                     op_tally [4];
    int                     refused_inserts = 0;
    int                     times_full = 0;

    always #2 aclk = ~aclk;

    linear_search_key_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lskt_result_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (mismatch_count),
        .results_pending (results_pending)
    );

    // Idle bursts are allowed except in every third stretch and in the final part.
    function automatic bit idle_allowed(input int stretch);
        return (requests_accepted < TOTAL_REQUESTS - CALM_TAIL) && (stretch % 3 != 2);
    endfunction

    // Picks a key: a stored one with the given chance, else a corner value or a random one.
    function automatic logic [KEY_W-1:0] pick_key(input int known_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < known_pct && known_keys.size() > 0) begin
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        end
        if (roll < known_pct + 12) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    // Offers one request after an optional gap and holds it until the transfer.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        int hits[$];
        if (idle_allowed(requests_accepted / 40) && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({key, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_accepted++;
        op_tally[op]++;
        @(negedge aclk);
        // Keep the steering list in step with the table.
        if (op == OP_INSERT) begin
            if (known_keys.size() < CAPACITY) begin
                known_keys.push_back(key);
                if (known_keys.size() == CAPACITY) times_full++;
            end else begin
                refused_inserts++;
            end
        end else if (op == OP_REMOVE) begin
            hits = known_keys.find_first_index(item) with (item == key);
            if (hits.size() > 0) known_keys.delete(hits[0]);
        end
    endtask

    // Request stimulus and verdict.
    initial begin
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               roll;
        bit               filling;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: empty table, corner keys, duplicates, moves on remove,
        // absent keys and the unused code.
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h0000_0001);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h5555_5555);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'hAAAA_AAAA);
        send_request(OP_REMOVE, 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_UNUSED, 32'h0000_0000);

        // Random part: fill the table with mostly inserts, probe it while full,
        // then drain it with mostly removes and searches.
        filling = 1'b1;
        while (requests_accepted < TOTAL_REQUESTS) begin
            roll = $urandom_range(0, 99);
            if (known_keys.size() == CAPACITY) begin
                filling = 1'b0;
                op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_SEARCH : OP_REMOVE;
            end else if (filling) begin
                op = (roll < 82) ? OP_INSERT : (roll < 92) ? OP_SEARCH :
                     (roll < 96) ? OP_REMOVE : OP_UNUSED;
            end else begin
                op = (roll < 50) ? OP_REMOVE : (roll < 78) ? OP_SEARCH :
                     (roll < 93) ? OP_INSERT : OP_UNUSED;
            end
            key = pick_key((op == OP_INSERT) ? 25 : 70);
            send_request(op, key);
        end
        s_tvalid <= 1'b0;

        // Let every result arrive, then watch a while longer for stray transfers.
        while (results_pending != 0) @(negedge aclk);
        repeat (CAPACITY + 2) @(negedge aclk);

        $display("Covered %0d requests: %0d inserts, %0d removes, %0d searches, %0d unused.",
                 requests_accepted, op_tally[OP_INSERT], op_tally[OP_REMOVE],
                 op_tally[OP_SEARCH], op_tally[OP_UNUSED]);
        $display("Table reached capacity %0d time(s); %0d insert(s) refused as full.",
                 times_full, refused_inserts);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result back-pressure: random stall bursts and one long hold-off that
    // backs the block up while requests keep coming.
    initial begin
        int rx_cycles;
        int stall;
        bit held_off;
        rx_cycles = 0;
        held_off  = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (!held_off && requests_accepted >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                rx_cycles += HOLD_OFF_CYCLES;
            end else if (idle_allowed(rx_cycles / 64) && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
                rx_cycles += stall;
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
                rx_cycles++;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lskt_pkg.sv
design/lskt_ram.sv
design/lskt_seq.sv
design/linear_search_key_table.sv
sim/lskt_checker.sv
sim/tb.sv
